### rtl/triangle_tangent_from_uv_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the tangent unit checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FROM_UV_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_FROM_UV_UNIT_DEFINES_SVH

// property checked on every clock, disabled in reset
`define TTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must hold in the cycle after an output item is stalled
`define TTU_STALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (m_axis_tvalid && !m_axis_tready) |=> prop) else $error(msg);

`endif

### rtl/ttu_pkg.sv
// ----------------------------------------------------------------------------
// ttu_pkg
// Types and constants for the triangle tangent unit.
// ----------------------------------------------------------------------------
package ttu_pkg;

  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned OutIdxW      = 16;
  localparam int unsigned DeltaW       = 33;
  localparam int unsigned ProdW        = 66;
  localparam int unsigned NumW         = 67;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // One triangle job handed from the collector to the solver
  typedef struct packed {
    logic signed [DeltaW-1:0] dp0x, dp0y, dp0z, dp1x, dp1y, dp1z;
    logic signed [DeltaW-1:0] du0, dv0, du1, dv1;
    logic        [OutIdxW-1:0] index;
  } tri_job_t;

  typedef struct packed {
    logic signed [CoordW-1:0] tx, ty, tz;
    logic        [OutIdxW-1:0] index;
    logic                      degen;
  } tri_res_t;

endpackage

### rtl/ttu_collect.sv
// ----------------------------------------------------------------------------
// ttu_collect
// Front end: holds corners 0 and 1, counts triangles, emits delta jobs.
// ----------------------------------------------------------------------------
module ttu_collect import ttu_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i,
  input  logic                     mesh_start_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output tri_job_t                 job_o
);

  logic signed [CoordW-1:0] c0_q [5];
  logic signed [CoordW-1:0] c1_q [5];
  logic [1:0]               cnt_q, cnt_d, cnt_eff;
  logic [INDEX_BITS-1:0]    tri_q, tri_d, tri_eff;
  logic                     jv_q;
  tri_job_t                 job_q;
  logic                     acc;
  logic [OutIdxW-1:0]       idx_out;

  function automatic logic signed [DeltaW-1:0] sd(logic signed [CoordW-1:0] a,
                                                  logic signed [CoordW-1:0] b);
    sd = DeltaW'(a) - DeltaW'(b);
  endfunction

  assign in_ready_o  = !jv_q || job_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;
  assign cnt_eff     = mesh_start_i ? 2'd0 : cnt_q;
  assign tri_eff     = mesh_start_i ? '0 : tri_q;

  if (INDEX_BITS >= OutIdxW) begin : g_wide
    assign idx_out = tri_eff[OutIdxW-1:0];
  end else begin : g_narrow
    assign idx_out = OutIdxW'(tri_eff);
  end

  always_comb begin
    cnt_d = cnt_q;
    tri_d = tri_q;
    if (acc) begin
      if (cnt_eff == 2'd2) begin
        cnt_d = 2'd0;
        tri_d = tri_eff + 1'b1;
      end else begin
        cnt_d = cnt_eff + 1'b1;
        tri_d = tri_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tri_q <= '0;
      jv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      tri_q <= tri_d;
      if (acc) jv_q <= (cnt_eff == 2'd2);
      else if (job_ready_i) jv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (cnt_eff == 2'd0) begin
        c0_q[0] <= pos_x_i; c0_q[1] <= pos_y_i; c0_q[2] <= pos_z_i;
        c0_q[3] <= tex_u_i; c0_q[4] <= tex_v_i;
      end else if (cnt_eff == 2'd1) begin
        c1_q[0] <= pos_x_i; c1_q[1] <= pos_y_i; c1_q[2] <= pos_z_i;
        c1_q[3] <= tex_u_i; c1_q[4] <= tex_v_i;
      end else begin
        job_q.dp0x  <= sd(c1_q[0], c0_q[0]);
        job_q.dp0y  <= sd(c1_q[1], c0_q[1]);
        job_q.dp0z  <= sd(c1_q[2], c0_q[2]);
        job_q.dp1x  <= sd(pos_x_i, c0_q[0]);
        job_q.dp1y  <= sd(pos_y_i, c0_q[1]);
        job_q.dp1z  <= sd(pos_z_i, c0_q[2]);
        job_q.du0   <= sd(c1_q[3], c0_q[3]);
        job_q.dv0   <= sd(c1_q[4], c0_q[4]);
        job_q.du1   <= sd(tex_u_i, c0_q[3]);
        job_q.dv1   <= sd(tex_v_i, c0_q[4]);
        job_q.index <= idx_out;
      end
    end
  end

endmodule

### rtl/ttu_fifo.sv
// ----------------------------------------------------------------------------
// ttu_fifo
// Two-entry job queue between collector and solver.
// ----------------------------------------------------------------------------
module ttu_fifo import ttu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  tri_job_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output tri_job_t rd_data_o
);

  tri_job_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

### rtl/ttu_solve.sv
// ----------------------------------------------------------------------------
// ttu_solve
// Back end: determinant, numerators and a shared restoring divider.
// ----------------------------------------------------------------------------
module ttu_solve import ttu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  tri_job_t job_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output tri_res_t res_o
);

  localparam int unsigned DivW  = NumW + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(DivW + 1);
  localparam int unsigned StepW = 4;

  div_state_e st_q, st_d;
  logic [StepW-1:0]       ph_q;
  logic signed [ProdW-1:0] pa_q, pb_q;
  logic signed [NumW-1:0]  det_q;
  logic signed [NumW-1:0]  num_q [3];
  tri_job_t                job_q;
  logic [1:0]              comp_q;
  logic [DivW-1:0]         n_q, q_q;
  logic [NumW-1:0]         r_q, d_q;
  logic                    neg_q;
  logic [CntW-1:0]         bit_q;
  logic signed [CoordW-1:0] t_q [3];
  logic                    rv_q;
  logic                    degen_q;
  logic [NumW:0]           r_sh;
  logic [NumW:0]           r_sub;
  logic [CoordW-1:0]       qsat;
  logic signed [DeltaW-1:0] ma, mb;

  assign job_ready_o = (st_q == DIV_IDLE) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o.tx    = t_q[0];
  assign res_o.ty    = t_q[1];
  assign res_o.tz    = t_q[2];
  assign res_o.index = job_q.index;
  assign res_o.degen = degen_q;

  assign r_sh  = {r_q, n_q[DivW-1]};
  assign r_sub = r_sh - {1'b0, d_q};

  // product schedule: one multiplier pair, one product per cycle
  always_comb begin
    unique case (ph_q)
      4'd0: begin ma = job_q.du0; mb = job_q.dv1; end
      4'd1: begin ma = job_q.du1; mb = job_q.dv0; end
      4'd2: begin ma = job_q.dv1; mb = job_q.dp0x; end
      4'd3: begin ma = job_q.dv0; mb = job_q.dp1x; end
      4'd4: begin ma = job_q.dv1; mb = job_q.dp0y; end
      4'd5: begin ma = job_q.dv0; mb = job_q.dp1y; end
      4'd6: begin ma = job_q.dv1; mb = job_q.dp0z; end
      4'd7: begin ma = job_q.dv0; mb = job_q.dp1z; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    logic [DivW-1:0] lim;
    lim  = neg_q ? DivW'(64'h8000_0000) : DivW'(64'h7FFF_FFFF);
    qsat = (q_q > lim) ? lim[CoordW-1:0] : q_q[CoordW-1:0];
    if (neg_q) qsat = CoordW'(0) - qsat;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DIV_IDLE: if (job_valid_i && job_ready_o) st_d = DIV_RUN;
      DIV_RUN:  if (ph_q == 4'd15 && comp_q == 2'd2 && bit_q == '0) st_d = DIV_DONE;
                else if (ph_q == 4'd10 && det_q == '0) st_d = DIV_DONE;
      DIV_DONE: st_d = DIV_IDLE;
      default:  st_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DIV_IDLE;
      rv_q <= 1'b0;
      ph_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == DIV_DONE) rv_q <= 1'b1;
      else if (res_ready_i) rv_q <= 1'b0;
      if (st_q == DIV_IDLE) ph_q <= '0;
      else if (st_q == DIV_RUN && ph_q < 4'd15) begin
        if (ph_q == 4'd11) ph_q <= 4'd12;
        else if (ph_q != 4'd14 || bit_q == '0) ph_q <= ph_q + 1'b1;
      end else if (st_q == DIV_RUN && bit_q == '0) ph_q <= 4'd12;
    end
  end

  // phases: 0..8 multiply and subtract, 10 check det, 12 load, 13 wait,
  // 14 iterate, 15 store and next component
  always_ff @(posedge clk_i) begin
    if (st_q == DIV_IDLE && job_valid_i && job_ready_o) begin
      job_q  <= job_i;
      comp_q <= '0;
    end
    if (st_q == DIV_RUN) begin
      if (ph_q <= 4'd7) begin
        pb_q <= pa_q;
        pa_q <= ProdW'(ma) * ProdW'(mb);
      end
      if (ph_q == 4'd2) det_q <= NumW'(pb_q) - NumW'(pa_q);
      if (ph_q == 4'd4) num_q[0] <= NumW'(pb_q) - NumW'(pa_q);
      if (ph_q == 4'd6) num_q[1] <= NumW'(pb_q) - NumW'(pa_q);
      if (ph_q == 4'd8) num_q[2] <= NumW'(pb_q) - NumW'(pa_q);
      if (ph_q == 4'd10) begin
        degen_q <= (det_q == '0);
        t_q[0] <= '0; t_q[1] <= '0; t_q[2] <= '0;
      end
      if (ph_q == 4'd12) begin
        neg_q <= num_q[comp_q][NumW-1] ^ det_q[NumW-1];
        n_q   <= {(num_q[comp_q][NumW-1] ? -num_q[comp_q] : num_q[comp_q]),
                  {FRAC_BITS{1'b0}}};
        d_q   <= det_q[NumW-1] ? -det_q : det_q;
        r_q   <= '0;
        q_q   <= '0;
        bit_q <= CntW'(DivW);
      end
      if (ph_q == 4'd14 && bit_q != '0) begin
        n_q   <= {n_q[DivW-2:0], 1'b0};
        if (!r_sub[NumW]) begin
          r_q <= r_sub[NumW-1:0];
          q_q <= {q_q[DivW-2:0], 1'b1};
        end else begin
          r_q <= r_sh[NumW-1:0];
          q_q <= {q_q[DivW-2:0], 1'b0};
        end
        bit_q <= bit_q - 1'b1;
      end
      if (ph_q == 4'd15) begin
        t_q[comp_q] <= qsat;
        comp_q <= comp_q + 1'b1;
      end
    end
  end

endmodule

### rtl/triangle_tangent_from_uv_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_unit
// Per-triangle tangent from UV deltas, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Corners are accepted one per cycle while the job output is not stalled;
// every third corner completes a triangle whose deltas go through a two-deep
// queue to the solver. The solver shares one multiplier for the eight
// products and one restoring divider that gives one quotient bit per cycle,
// 83 bits per component at FRAC_BITS=16; a degenerate triangle (zero UV
// determinant) finishes after the determinant check with a zero tangent.
module triangle_tangent_from_uv_unit import ttu_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         s_axis_tuser,   // mesh_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // tangent_x, tangent_y, tangent_z, tangent_index
  output logic         m_axis_tuser    // degenerate
);

  logic     jv, jr, qv, qr;
  tri_job_t jd, qd;
  tri_res_t res;

  ttu_collect #(.INDEX_BITS(INDEX_BITS)) u_col (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .pos_x_i(s_axis_tdata[31:0]), .pos_y_i(s_axis_tdata[63:32]),
    .pos_z_i(s_axis_tdata[95:64]), .tex_u_i(s_axis_tdata[127:96]),
    .tex_v_i(s_axis_tdata[159:128]), .mesh_start_i(s_axis_tuser),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(jd)
  );

  ttu_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(jv), .wr_ready_o(jr), .wr_data_i(jd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  ttu_solve #(.FRAC_BITS(FRAC_BITS)) u_solve (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {res.index, res.tz, res.ty, res.tx};
  assign m_axis_tuser = res.degen;

endmodule

### rtl/ttu_checker.sv
// ----------------------------------------------------------------------------
// ttu_checker
// Port-level checks for the tangent unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_tangent_from_uv_unit_defines.svh"

module ttu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  `TTU_ASSERT(a_degen, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:0] == '0, "degen nonzero")
  `TTU_STALL(a_hold_valid, m_axis_tvalid, "output valid dropped while stalled")
  `TTU_STALL(a_hold_data, $stable(m_axis_tdata), "output data changed while stalled")
  `TTU_STALL(a_hold_user, $stable(m_axis_tuser), "degenerate flag changed while stalled")

endmodule

bind triangle_tangent_from_uv_unit ttu_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

### sim/tb_triangle_tangent_from_uv_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_from_uv_unit
// Streams triangle corners into the tangent unit and checks every tangent item
// against an in-bench predictor. The run covers directed extremes, degenerate
// and saturating triangles, a back-to-back burst, and random meshes, with
// random gaps on both buses.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_from_uv_unit;
  import ttu_pkg::*;

  localparam int unsigned WdogLimit = 20000;
  localparam logic [31:0] MaxC = 32'h7fff_ffff;
  localparam logic [31:0] MinC = 32'h8000_0000;

  typedef enum logic {CORNER, HOLD} item_kind_e;

  typedef struct {
    item_kind_e   kind;
    logic [159:0] data;
    logic         start;
    logic         fast;
  } corner_item_t;

  typedef struct {
    logic [31:0] tx, ty, tz;
    logic [15:0] index;
    logic        degen;
  } tangent_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
  logic         s_axis_tuser = 1'b0; // mesh_start
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;        // tangent_x, tangent_y, tangent_z, tangent_index
  logic         m_axis_tuser;        // degenerate

  corner_item_t corners_q[$];
  tangent_t     tangents_due[$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  logic         fast_now = 1'b0;

  logic signed [31:0] held [2][5];
  int unsigned        corner_cnt = 0;
  logic [15:0]        tri_cnt = '0;

  triangle_tangent_from_uv_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic signed [31:0] fixed_quot(logic signed [127:0] num,
                                                    logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FracBitsDef) / den;
    if (q > 128'sh7fff_ffff) return MaxC;
    if (q < -128'sh8000_0000) return MinC;
    return q[31:0];
  endfunction

  task automatic predict_tangent(corner_item_t it);
    logic signed [31:0]  c [5];
    logic signed [127:0] dp0 [3], dp1 [3], du0, dv0, du1, dv1, det, num;
    logic signed [31:0]  t [3];
    tangent_t            r;
    for (int j = 0; j < 5; j++) c[j] = it.data[32*j +: 32];
    if (it.start) begin
      corner_cnt = 0;
      tri_cnt = '0;
    end
    if (corner_cnt < 2) begin
      held[corner_cnt] = c;
      corner_cnt++;
      return;
    end
    for (int j = 0; j < 3; j++) begin
      dp0[j] = 128'(held[1][j]) - 128'(held[0][j]);
      dp1[j] = 128'(c[j]) - 128'(held[0][j]);
    end
    du0 = 128'(held[1][3]) - 128'(held[0][3]);
    dv0 = 128'(held[1][4]) - 128'(held[0][4]);
    du1 = 128'(c[3]) - 128'(held[0][3]);
    dv1 = 128'(c[4]) - 128'(held[0][4]);
    det = du0 * dv1 - du1 * dv0;
    for (int j = 0; j < 3; j++) begin
      num = dv1 * dp0[j] - dv0 * dp1[j];
      t[j] = (det == 0) ? 32'sd0 : fixed_quot(num, det);
    end
    r.tx = t[0];
    r.ty = t[1];
    r.tz = t[2];
    r.index = tri_cnt;
    r.degen = (det == 0);
    tangents_due.push_back(r);
    tri_cnt++;
    corner_cnt = 0;
  endtask

  int unsigned calm_left = 0;
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) calm_left = $urandom_range(20, 120);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int unsigned  send_gap = 0;
  corner_item_t cur;
  always @(posedge clk_i) begin
    logic nv;
    logic acc;
    acc = s_axis_tvalid && s_axis_tready;
    if (acc) predict_tangent(cur);
    if (rst_ni && (!s_axis_tvalid || acc)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (corners_q.size() > 0) begin
        if (corners_q[0].kind == HOLD) begin
          if (tangents_due.size() == 0) void'(corners_q.pop_front());
        end else begin
          cur = corners_q.pop_front();
          fast_now <= cur.fast;
          nv = 1'b1;
          send_gap = cur.fast ? 0 : pick_gap();
        end
      end
      s_axis_tvalid <= nv;
      if (nv) begin
        s_axis_tdata <= cur.data;
        s_axis_tuser <= cur.start;
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    tangent_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (tangents_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h degen %b", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        e = tangents_due.pop_front();
        if (m_axis_tdata[31:0] !== e.tx) begin
          errors++;
          $display("%0t: tangent_x exp %h got %h", $time, e.tx, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[63:32] !== e.ty) begin
          errors++;
          $display("%0t: tangent_y exp %h got %h", $time, e.ty, m_axis_tdata[63:32]);
        end
        if (m_axis_tdata[95:64] !== e.tz) begin
          errors++;
          $display("%0t: tangent_z exp %h got %h", $time, e.tz, m_axis_tdata[95:64]);
        end
        if (m_axis_tdata[111:96] !== e.index) begin
          errors++;
          $display("%0t: index exp %h got %h", $time, e.index, m_axis_tdata[111:96]);
        end
        if (m_axis_tuser !== e.degen) begin
          errors++;
          $display("%0t: degenerate exp %b got %b", $time, e.degen, m_axis_tuser);
        end
      end
    end
    if (rst_ni) begin
      if (fast_now) begin
        m_axis_tready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdogLimit) begin
      $display("tb_triangle_tangent_from_uv_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return MaxC;
      1: return MinC;
      2: return 32'($signed($urandom_range(0, 4)) - 2);
      3, 4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_corner(logic [31:0] x, y, z, u, v, logic start, logic fast = 1'b0);
    corner_item_t it;
    it.kind = CORNER;
    it.data = {v, u, z, y, x};
    it.start = start;
    it.fast = fast;
    corners_q.push_back(it);
  endtask

  task automatic add_hold();
    corner_item_t it;
    it.kind = HOLD;
    it.data = '0;
    it.start = 1'b0;
    it.fast = 1'b0;
    corners_q.push_back(it);
  endtask

  task automatic add_random_triangle();
    logic [31:0] u0, v0;
    logic        degen;
    u0 = rand_coord();
    v0 = rand_coord();
    degen = ($urandom_range(0, 15) == 0);
    add_corner(rand_coord(), rand_coord(), rand_coord(), u0, v0,
               $urandom_range(0, 24) == 0);
    add_corner(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               $urandom_range(0, 40) == 0);
    if (degen)
      add_corner(rand_coord(), rand_coord(), rand_coord(), u0, v0, 1'b0);
    else
      add_corner(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 40) == 0);
  endtask

  initial begin
    // plain triangle, unit UV square
    add_corner(0, 0, 0, 0, 0, 1'b1);
    add_corner(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
    add_corner(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
    // extremes everywhere
    add_corner(MinC, MinC, MinC, MinC, MinC, 1'b0);
    add_corner(MaxC, MaxC, MaxC, MaxC, 0, 1'b0);
    add_corner(MaxC, MinC, MaxC, 0, MaxC, 1'b0);
    // zero determinant
    add_corner(5, 6, 7, 32'h0002_0000, 32'h0003_0000, 1'b0);
    add_corner(MaxC, 1, MinC, 32'h0004_0000, 32'h0006_0000, 1'b0);
    add_corner(MinC, 2, MaxC, 32'h0006_0000, 32'h0009_0000, 1'b0);
    // det of one with huge positions: saturates both ways
    add_corner(MinC, MaxC, 0, 0, 0, 1'b0);
    add_corner(MaxC, MinC, 1, 1, 0, 1'b0);
    add_corner(MinC, MaxC, 0, 0, 1, 1'b0);
    // restart in the middle of a triangle
    add_corner(1, 2, 3, 4, 5, 1'b0);
    add_corner(MaxC, MaxC, MaxC, MaxC, MaxC, 1'b1);
    add_corner(0, 0, 0, 0, 0, 1'b0);
    add_corner(MinC, MinC, MinC, 0, MinC, 1'b0);
    add_hold();
    // back-to-back burst of degenerate triangles
    for (int i = 0; i < 4; i++) begin
      add_corner($urandom, $urandom, $urandom, 0, 0, i == 0, 1'b1);
      add_corner($urandom, $urandom, $urandom, 0, 0, 1'b0, 1'b1);
      add_corner($urandom, $urandom, $urandom, 0, 0, 1'b0, 1'b1);
    end
    add_hold();
    for (int i = 0; i < 535; i++) begin
      if (i == 267) add_hold();
      if ($urandom_range(0, 20) == 0)
        add_corner(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 1));
      add_random_triangle();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (corners_q.size() != 0 || s_axis_tvalid || tangents_due.size() != 0);
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_triangle_tangent_from_uv_unit: clean");
    end else begin
      $display("tb_triangle_tangent_from_uv_unit: errors");
    end
    $finish;
  end

endmodule
